### rtl/grb_pkg.sv
// ----------------------------------------------------------------------------
// grb_pkg: shared types and constants of the group reverse buffer
// Command and release records passed between the front, queue and back.
// ----------------------------------------------------------------------------
package grb_pkg;

  localparam int DATA_W = 32;
  localparam int GS_W   = 7;

  // register index decoded from paddr[2]
  localparam logic REG_GROUP_SIZE = 1'b0;

  localparam logic [GS_W-1:0] GROUP_SIZE_RESET = 7'd4;

  // one buffered run to emit
  typedef struct packed {
    logic bank;   // ping-pong half holding the run
    logic rev;    // emit newest first
    logic done;   // run closes the list
  } cmd_t;

  // back end has finished reading a half
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

### rtl/grb_front.sv
// ----------------------------------------------------------------------------
// grb_front: input side of the group reverse buffer
// Writes each value into the active half, counts the run and issues a
// command when the group fills or the list ends.
// ----------------------------------------------------------------------------
module grb_front import grb_pkg::*; #(
  parameter int MAX_GROUP = 64,
  localparam int IW = $clog2(MAX_GROUP),
  localparam int KW = $clog2(MAX_GROUP + 1),
  localparam int CW = (KW > GS_W) ? KW : GS_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [GS_W-1:0]          group_size,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] item_value,
  input  logic                     list_end,
  output logic                     wr_en,
  output logic [IW:0]              wr_addr,
  output logic [DATA_W-1:0]        wr_data,
  output logic                     push,
  output cmd_t                     cmd,
  output logic [IW-1:0]            cmd_top,
  input  rel_t                     rel
);

  logic [IW-1:0] fill;
  logic [IW-1:0] fill_next;
  logic          bank;
  logic [1:0]    busy;
  logic [1:0]    busy_next;
  logic          accept;
  logic [CW-1:0] gs_w;
  logic [CW-1:0] k;
  logic [CW-1:0] n_w;
  logic          emit_rev;

  assign in_ready = !busy[bank];
  assign accept   = in_valid && in_ready;

  // effective group size: 0 and 1 pass through, large sizes saturate
  assign gs_w = CW'(group_size);
  always_comb begin
    if (gs_w <= CW'(1)) begin
      k = CW'(1);
    end else if (gs_w > CW'(MAX_GROUP)) begin
      k = CW'(MAX_GROUP);
    end else begin
      k = gs_w;
    end
  end

  assign n_w      = CW'(fill) + CW'(1);
  assign emit_rev = (n_w >= k);

  assign wr_en   = accept;
  assign wr_addr = {bank, fill};
  assign wr_data = item_value;

  assign push     = accept && (emit_rev || list_end);
  assign cmd.bank = bank;
  assign cmd.rev  = emit_rev;
  assign cmd.done = list_end;
  assign cmd_top  = fill;

  always_comb begin
    fill_next = fill;
    if (push) begin
      fill_next = '0;
    end else if (accept) begin
      fill_next = fill + IW'(1);
    end
  end

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bank <= 1'b0;
      busy <= 2'b00;
    end else begin
      fill <= fill_next;
      busy <= busy_next;
      if (push) begin
        bank <= !bank;
      end
    end
  end

  // the back end only frees a half that holds a run
  a_rel_busy: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> busy[rel.bank])
    else $error("release of a half that is not busy");

  // a half being freed is never the one being closed in the same cycle
  a_rel_push: assert property (@(posedge clk) disable iff (rst)
    (push && rel.valid) |-> (rel.bank != bank))
    else $error("release and push hit the same half");

endmodule

### rtl/grb_cmd_queue.sv
// ----------------------------------------------------------------------------
// grb_cmd_queue: two-entry command queue
// Holds run commands between the front and the back end.
// ----------------------------------------------------------------------------
module grb_cmd_queue import grb_pkg::*; #(
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          cmd_in,
  input  logic [IW-1:0] top_in,
  output logic          q_valid,
  output cmd_t          cmd_out,
  output logic [IW-1:0] top_out,
  input  logic          pop
);

  cmd_t          cmd_q [2];
  logic [IW-1:0] top_q [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;

  assign q_valid = (count != 2'd0);
  assign cmd_out = cmd_q[rp];
  assign top_out = top_q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wp] <= cmd_in;
      top_q[wp] <= top_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2) || pop)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != 2'd0))
    else $error("command queue underflow");

endmodule

### rtl/grb_back.sv
// ----------------------------------------------------------------------------
// grb_back: output side of the group reverse buffer
// Owns the ping-pong value store and drains one run per command, forward or
// reversed, into the output register.
// ----------------------------------------------------------------------------
module grb_back import grb_pkg::*; #(
  parameter int MAX_GROUP = 64,
  localparam int IW = $clog2(MAX_GROUP)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [IW:0]              wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     q_valid,
  input  cmd_t                     q_cmd,
  input  logic [IW-1:0]            q_top,
  output logic                     q_pop,
  output rel_t                     rel,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     run_last,
  output logic                     list_done
);

  // each half spans the full index range so {bank, index} stays in bounds
  logic [DATA_W-1:0] store [2**(IW+1)];

  logic          active;
  cmd_t          cur;
  logic [IW-1:0] top;
  logic [IW-1:0] cnt;
  logic          issue;
  logic          last;
  logic          finishing;
  logic [IW-1:0] idx;

  assign issue     = active && (!out_valid || out_ready);
  assign last      = (cnt == top);
  assign finishing = issue && last;
  assign q_pop     = q_valid && (!active || finishing);
  assign idx       = cur.rev ? (top - cnt) : cnt;

  assign rel.valid = finishing;
  assign rel.bank  = cur.bank;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (finishing) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
      top <= q_top;
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + IW'(1);
    end
  end

  // read straight into the output register; hold it while stalled
  always_ff @(posedge clk) begin
    if (issue) begin
      out_value <= $signed(store[{cur.bank, idx}]);
      run_last  <= last;
      list_done <= last && cur.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/group_reverse_buffer_unit.sv
// ----------------------------------------------------------------------------
// group_reverse_buffer_unit: stream reversal in groups of a configured size
// Values enter on the in_valid/in_ready channel with item_value and list_end.
// Results leave on out_valid/out_ready with out_value, run_last (last result
// of a run) and list_done (final element of the list).
// A full group leaves newest first; a partial group closed by list_end leaves
// in arrival order. group_size 0 or 1 passes values through; above MAX_GROUP
// it saturates. group_size sits at APB byte address 0, reset value 4.
// The input that closes a run queues its command; the back end pops it and reads
// the store into the output register, one store read per cycle unless stalled,
// and a run already queued follows the previous one with no gap.
// Inputs are taken one per cycle while a half of the ping-pong store is free;
// in_ready drops once both halves hold runs waiting to drain.
// Reset empties the command queue, frees both halves and clears the fill
// count; the store keeps its contents. A stalled receiver holds the output
// register and the drain, and backs up into the input once both halves fill.
// ----------------------------------------------------------------------------
module group_reverse_buffer_unit import grb_pkg::*; #(
  parameter int MAX_GROUP = 64,
  localparam int IW = $clog2(MAX_GROUP)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] item_value,
  input  logic                     list_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     run_last,
  output logic                     list_done
);

  logic [GS_W-1:0]   group_size;
  logic              reg_idx;
  logic              wr_en;
  logic [IW:0]       wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              push;
  cmd_t              cmd;
  logic [IW-1:0]     cmd_top;
  logic              q_valid;
  cmd_t              q_cmd;
  logic [IW-1:0]     q_top;
  logic              q_pop;
  rel_t              rel;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign prdata  = (reg_idx == REG_GROUP_SIZE) ? {{(32-GS_W){1'b0}}, group_size} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_GROUP_SIZE)) begin
      group_size <= pwdata[GS_W-1:0];
    end
  end

  grb_front #(.MAX_GROUP(MAX_GROUP)) u_front (
    .clk        (clk),
    .rst        (rst),
    .group_size (group_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_value (item_value),
    .list_end   (list_end),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push),
    .cmd        (cmd),
    .cmd_top    (cmd_top),
    .rel        (rel)
  );

  grb_cmd_queue #(.IW(IW)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd),
    .top_in  (cmd_top),
    .q_valid (q_valid),
    .cmd_out (q_cmd),
    .top_out (q_top),
    .pop     (q_pop)
  );

  grb_back #(.MAX_GROUP(MAX_GROUP)) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_top     (q_top),
    .q_pop     (q_pop),
    .rel       (rel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .run_last  (run_last),
    .list_done (list_done)
  );

endmodule
